// ----- hdl/pidt_pkg.sv -----
// Shared types and constants of the PID temperature regulator.
// Used by the multiply-accumulate unit, the serial divider and the top level.
// No dependencies.
`timescale 1ns / 1ps

package pidt_pkg;

	localparam int DRIVE_W = 16;
	localparam int OPA_W   = 17;
	localparam int SUM_W   = 28;
	localparam int INT_W   = 18;
	localparam int DIVD_W  = SUM_W - 1;

	localparam logic [DRIVE_W-1:0] FIXED_DRIVE = 16'd10;
	localparam logic [DRIVE_W-1:0] DRIVE_MAX   = 16'hFFFF;

	localparam logic [9:0]  RST_OVERTEMP_LIMIT  = 10'd450;
	localparam logic [9:0]  RST_PRECONTROL_BAND = 10'd50;
	localparam logic [7:0]  RST_GAIN_P          = 8'd8;
	localparam logic [15:0] RST_P_LIMIT         = 16'd1000;
	localparam logic [14:0] RST_I_LIMIT         = 15'd500;
	localparam logic [7:0]  RST_GAIN_I          = 8'd1;
	localparam logic [7:0]  RST_GAIN_D          = 8'd2;
	localparam logic [15:0] RST_OUTPUT_DIVISOR  = 16'd100;

	typedef enum logic [2:0] {
		REG_OVERTEMP_LIMIT  = 3'd0,
		REG_PRECONTROL_BAND = 3'd1,
		REG_GAIN_P          = 3'd2,
		REG_P_LIMIT         = 3'd3,
		REG_I_LIMIT         = 3'd4,
		REG_GAIN_I          = 3'd5,
		REG_GAIN_D          = 3'd6,
		REG_OUTPUT_DIVISOR  = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_P,
		S_I,
		S_D,
		S_DSTART,
		S_DIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic en;
		logic first;
		logic clamp;
	} mac_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ----- hdl/pid_temperature_regulator_top.sv -----
// Top level of the PID temperature regulator: registers, sequencer and output stage.
// Depends on pidt_pkg, pidt_mac and pidt_div.
//
//   Channel  Direction  Handshake              Content
//   s_axis   in         s_axis_tvalid/tready   measured and target temperature
//   m_axis   out        m_axis_tvalid/tready   drive level
//   cfg      in         cfg_valid/cfg_ready    register index and write data
//
// An overtemperature or precontrol sample goes from its transaction straight to the output
// state. A PID sample takes three passes through the shared multiply-accumulate unit,
// one divider load, the serial divide, the taking of the quotient and the output state.
// The sequencer returns to idle as it loads the output register, so a new input
// transaction can only follow once the previous sample has been loaded there.
// The input is ready only while the sequencer is idle; one result waits in the output
// register, and the sequencer holds a finished result until that register is free.
// Reset is asynchronous and needs no clearing pass; configuration is always ready.
`timescale 1ns / 1ps

module pid_temperature_regulator_top #(
	parameter int TEMP_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// Fields from bit 0: measured_temp, target_temp, zero fill.
	input  logic [((2*TEMP_BITS+7)/8)*8-1:0]      s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// Fields from bit 0: drive_level.
	output logic [15:0]                           m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [2:0]                            cfg_index,
	input  logic [15:0]                           cfg_data
);
	import pidt_pkg::*;

	localparam int EW = TEMP_BITS + 1;
	localparam int LW = TEMP_BITS + 2;

	logic [9:0]  ot_limit_q;
	logic [9:0]  band_q;
	logic [7:0]  gain_p_q;
	logic [15:0] p_limit_q;
	logic [14:0] i_limit_q;
	logic [7:0]  gain_i_q;
	logic [7:0]  gain_d_q;
	logic [15:0] divisor_q;

	state_t state_q, state_d;

	logic signed [EW-1:0]    err_q;
	logic signed [LW-1:0]    last_error_q;
	logic signed [LW-1:0]    d_q;
	logic signed [15:0]      integral_sum_q;
	logic [DRIVE_W-1:0]      res_q;
	logic [DRIVE_W-1:0]      out_data_q;
	logic                    out_valid_q;

	logic [TEMP_BITS-1:0]    meas_in;
	logic [TEMP_BITS-1:0]    targ_in;
	logic signed [EW-1:0]    err_in;
	logic                    in_hs;
	logic                    overtemp;
	logic                    precontrol;
	logic                    out_free;

	logic signed [INT_W-1:0] ib;
	logic signed [INT_W-1:0] il;
	logic signed [INT_W-1:0] ie;
	logic signed [INT_W-1:0] it;
	logic signed [INT_W-1:0] ic;

	mac_ctrl_t               mac_ctrl;
	logic signed [OPA_W-1:0] mac_a;
	logic [7:0]              mac_b;
	logic signed [SUM_W-1:0] acc;

	logic                    div_start;
	logic [DIVD_W-1:0]       div_dividend;
	logic [15:0]             div_divisor;
	logic [DIVD_W-1:0]       quotient;
	div_status_t             div_st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ot_limit_q <= RST_OVERTEMP_LIMIT;
			band_q     <= RST_PRECONTROL_BAND;
			gain_p_q   <= RST_GAIN_P;
			p_limit_q  <= RST_P_LIMIT;
			i_limit_q  <= RST_I_LIMIT;
			gain_i_q   <= RST_GAIN_I;
			gain_d_q   <= RST_GAIN_D;
			divisor_q  <= RST_OUTPUT_DIVISOR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_OVERTEMP_LIMIT:  ot_limit_q <= cfg_data[9:0];
				REG_PRECONTROL_BAND: band_q     <= cfg_data[9:0];
				REG_GAIN_P:          gain_p_q   <= cfg_data[7:0];
				REG_P_LIMIT:         p_limit_q  <= cfg_data;
				REG_I_LIMIT:         i_limit_q  <= cfg_data[14:0];
				REG_GAIN_I:          gain_i_q   <= cfg_data[7:0];
				REG_GAIN_D:          gain_d_q   <= cfg_data[7:0];
				REG_OUTPUT_DIVISOR:  divisor_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		meas_in    = s_axis_tdata[TEMP_BITS-1:0];
		targ_in    = s_axis_tdata[2*TEMP_BITS-1:TEMP_BITS];
		err_in     = $signed({1'b0, targ_in}) - $signed({1'b0, meas_in});
		overtemp   = 16'(meas_in) > 16'(ot_limit_q);
		precontrol = INT_W'(err_in) > $signed(INT_W'(band_q));
		in_hs      = s_axis_tvalid && s_axis_tready;
		out_free   = !out_valid_q || m_axis_tready;
	end

	always_comb begin
		ib = INT_W'(integral_sum_q);
		il = $signed(INT_W'(i_limit_q));
		ie = INT_W'(err_q);
		it = ((ib < il) && (err_q > 0)) ? ib + ie : ib;
		if (it > il) begin
			ic = il;
		end else if (it < -il) begin
			ic = -il;
		end else begin
			ic = it;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		mac_ctrl      = '0;
		mac_a         = OPA_W'(err_q);
		mac_b         = gain_p_q;
		div_start     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = (overtemp || precontrol) ? S_OUT : S_P;
				end
			end
			S_P: begin
				mac_ctrl = '{en: 1'b1, first: 1'b1, clamp: 1'b1};
				state_d  = S_I;
			end
			S_I: begin
				mac_ctrl = '{en: 1'b1, first: 1'b0, clamp: 1'b0};
				mac_a    = OPA_W'(integral_sum_q);
				mac_b    = gain_i_q;
				state_d  = S_D;
			end
			S_D: begin
				mac_ctrl = '{en: 1'b1, first: 1'b0, clamp: 1'b0};
				mac_a    = OPA_W'(d_q);
				mac_b    = gain_d_q;
				state_d  = S_DSTART;
			end
			S_DSTART: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_st.done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q   <= '0;
			integral_sum_q <= '0;
		end else if (state_q == S_P) begin
			last_error_q   <= LW'(err_q);
			integral_sum_q <= ic[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_hs) begin
			err_q <= err_in;
			if (overtemp) begin
				res_q <= '0;
			end else if (precontrol) begin
				res_q <= FIXED_DRIVE;
			end
		end
		if (state_q == S_P) begin
			d_q <= LW'(err_q) - last_error_q;
		end
		if (state_q == S_DIV && div_st.done) begin
			res_q <= (|quotient[DIVD_W-1:DRIVE_W]) ? DRIVE_MAX : quotient[DRIVE_W-1:0];
		end
	end

	assign div_dividend = acc[SUM_W-1] ? '0 : acc[DIVD_W-1:0];
	assign div_divisor  = (divisor_q == '0) ? 16'd1 : divisor_q;

	pidt_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.op_a   (mac_a),
		.op_b   (mac_b),
		.limit  (p_limit_q),
		.acc    (acc)
	);

	pidt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.status   (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_data_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_ready_not_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_st.busy)
		else $error("input ready while the divider is busy");

	a_done_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	a_overtemp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_hs && overtemp) |=> (state_q == S_OUT && res_q == '0))
		else $error("overtemperature sample did not yield zero drive");

	a_integral_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_P |=> (INT_W'(integral_sum_q) <= $signed(INT_W'(i_limit_q))
			&& INT_W'(integral_sum_q) >= -$signed(INT_W'(i_limit_q))))
		else $error("integral left its clamp range");

endmodule

// ----- hdl/pidt_mac.sv -----
// Shared multiply-accumulate unit with an optional symmetric clamp on the product.
// Depends on pidt_pkg.
`timescale 1ns / 1ps

module pidt_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pidt_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [pidt_pkg::OPA_W-1:0]   op_a,
	input  logic [7:0]                          op_b,
	input  logic [15:0]                         limit,
	output logic signed [pidt_pkg::SUM_W-1:0]   acc
);
	import pidt_pkg::*;

	logic signed [OPA_W+8:0]  prod;
	logic signed [SUM_W-1:0]  prod_x;
	logic signed [SUM_W-1:0]  lim_x;
	logic signed [SUM_W-1:0]  term;
	logic signed [SUM_W-1:0]  acc_q;

	always_comb begin
		prod   = op_a * $signed({1'b0, op_b});
		prod_x = SUM_W'(prod);
		lim_x  = $signed(SUM_W'(limit));
		term   = prod_x;
		if (ctrl.clamp) begin
			if (prod_x > lim_x) begin
				term = lim_x;
			end else if (prod_x < -lim_x) begin
				term = -lim_x;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.en) begin
			acc_q <= (ctrl.first ? '0 : acc_q) + term;
		end
	end

	assign acc = acc_q;

endmodule

// ----- hdl/pidt_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on pidt_pkg.
`timescale 1ns / 1ps

module pidt_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pidt_pkg::DIVD_W-1:0]     dividend,
	input  logic [15:0]                     divisor,
	output logic [pidt_pkg::DIVD_W-1:0]     quotient,
	output pidt_pkg::div_status_t           status
);
	import pidt_pkg::*;

	localparam int CW = $clog2(DIVD_W);

	logic [DIVD_W-1:0] quo_q;
	logic [15:0]       rem_q;
	logic [15:0]       dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [16:0]       shifted;
	logic              ge;
	logic [15:0]       rem_next;

	always_comb begin
		shifted  = {rem_q, quo_q[DIVD_W-1]};
		ge       = shifted >= {1'b0, dvs_q};
		rem_next = ge ? 16'(shifted - {1'b0, dvs_q}) : shifted[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DIVD_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule
